// ===== hw/rtl/moving_window_rms_threshold_core_macros.svh =====
// assertion helpers used by the core rtl file
`ifndef MOVING_WINDOW_RMS_THRESHOLD_CORE_MACROS_SVH
`define MOVING_WINDOW_RMS_THRESHOLD_CORE_MACROS_SVH

// same-cycle implication, checks skipped while reset is high
`define MWRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mwrt assertion failed");

// next-cycle implication, checks skipped while reset is high
`define MWRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mwrt assertion failed");

`endif

// ===== hw/rtl/mwrt_pkg.sv =====
package mwrt_pkg;

  // default configuration of the core
  localparam int WINDOW_LENGTH_DEF = 8;
  localparam int SAMPLE_BITS_DEF   = 16;

  // fixed field widths
  localparam int IN_W   = 16;
  localparam int RMS_W  = 16;
  localparam int THR_W  = 16;
  localparam int OUT_W  = 24;

  // dark_threshold value after reset
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd5000;

endpackage

// ===== hw/rtl/moving_window_rms_threshold_core.sv =====
// channel   direction  fields (lsb up)                          handshake
// s_*       in         tdata: light_sample[15:0]                 tvalid/tready
// m_*       out        tdata: rms_value[15:0], below_threshold   tvalid/tready
// cfg_*     in         cfg_wdata: dark_threshold[15:0]            cfg_wen, no wait
//
// one item at a time: accept, load, shift-add square, window update, bit-serial
// divide by the window length (SUM_W = 2*SAMPLE_BITS+clog2(WINDOW_LENGTH) bits),
// digit-by-digit root, output; the next item is taken only back in idle
// rst is synchronous: window reads as zeros (per-entry valid bits), position 0,
// threshold 5000; no clearing pass
// a finished result waits in the output register; the next item is taken while it
// waits, and only the final output step holds if the register is still full
`include "moving_window_rms_threshold_core_macros.svh"

module moving_window_rms_threshold_core #(
  parameter int WINDOW_LENGTH = mwrt_pkg::WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = mwrt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // slave side: light_sample[15:0]
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mwrt_pkg::IN_W-1:0]   s_tdata,
  // master side: rms_value[15:0], below_threshold[16], zeros above
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mwrt_pkg::OUT_W-1:0]  m_tdata,
  // configuration: dark_threshold
  input  logic                        cfg_wen,
  input  logic [mwrt_pkg::THR_W-1:0]  cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = 2 * SB + $clog2(WINDOW_LENGTH);
  localparam int RB    = $clog2(WINDOW_LENGTH) + 1;
  localparam int RMW   = SB + 2;
  localparam int CW    = (SB > mwrt_pkg::IN_W) ? SB : mwrt_pkg::IN_W;
  localparam int CNTW  = $clog2(SUM_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_SQR  = 7'b0000100,
    ST_SUM  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ROOT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t                     state;
  logic [CNTW-1:0]            cnt;
  logic [PW-1:0]              pos;
  logic [WINDOW_LENGTH-1:0]   valid;
  logic [SUM_W-1:0]           run_sum;
  logic [mwrt_pkg::THR_W-1:0] dark_threshold;

  logic [SB-1:0]              samp;
  logic [SB-1:0]              old;
  logic [2*SB-1:0]            p_new;
  logic [2*SB-1:0]            p_old;
  logic [SUM_W-1:0]           dv;
  logic [RB-1:0]              div_rem;
  logic [RMW-1:0]             rm;
  logic [SB-1:0]              root;

  logic [SB-1:0]              ram_rdata;
  logic                       ram_we;
  logic [CW-1:0]              in_ext;
  logic [SB-1:0]              old_val;
  logic [SB:0]                sum_new;
  logic [SB:0]                sum_old;
  logic [SUM_W-1:0]           run_sum_next;
  logic [RB:0]                div_trial;
  logic [RB-1:0]              div_rem_next;
  logic                       div_q;
  logic [RMW+1:0]             sq_sh;
  logic [RMW+1:0]             sq_trial;
  logic [RMW-1:0]             rm_next;
  logic [SB-1:0]              root_next;
  logic [CW-1:0]              root_ext;
  logic [CW-1:0]              thr_ext;
  logic                       s_accept;
  logic                       out_free;

  mwrt_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (samp),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ram_we   = (state == ST_SUM);
  assign in_ext   = CW'(s_tdata);

  always_comb begin
    // entries never written read as zero
    old_val      = valid[pos] ? ram_rdata : '0;
    // shift-add squaring, one multiplier bit a cycle
    sum_new      = {1'b0, p_new[2*SB-1:SB]} + (p_new[0] ? {1'b0, samp} : '0);
    sum_old      = {1'b0, p_old[2*SB-1:SB]} + (p_old[0] ? {1'b0, old} : '0);
    // drop the leaving square, add the new one
    run_sum_next = run_sum - SUM_W'(p_old) + SUM_W'(p_new);
    // restoring divide by the window length, one quotient bit a cycle
    div_trial    = {div_rem, dv[SUM_W-1]};
    div_q        = (div_trial >= (RB+1)'(WINDOW_LENGTH));
    div_rem_next = div_q ? RB'(div_trial - (RB+1)'(WINDOW_LENGTH)) : RB'(div_trial);
    // digit-by-digit root, one root bit per two radicand bits
    sq_sh        = {rm, dv[2*SB-1 -: 2]};
    sq_trial     = (RMW+2)'({root, 2'b01});
    if (sq_sh >= sq_trial) begin
      rm_next   = RMW'(sq_sh - sq_trial);
      root_next = {root[SB-2:0], 1'b1};
    end else begin
      rm_next   = RMW'(sq_sh);
      root_next = {root[SB-2:0], 1'b0};
    end
    root_ext     = CW'(root);
    thr_ext      = CW'(dark_threshold);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= mwrt_pkg::THRESHOLD_RESET;
    end else if (cfg_wen) begin
      dark_threshold <= cfg_wdata;
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pos      <= '0;
      valid    <= '0;
      run_sum  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result loads the output register, else a taken one empties it
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_SQR;
          cnt   <= CNTW'(SB - 1);
        end
        ST_SQR: begin
          if (cnt == '0) begin
            state <= ST_SUM;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SUM: begin
          state      <= ST_DIV;
          cnt        <= CNTW'(SUM_W - 1);
          run_sum    <= run_sum_next;
          valid[pos] <= 1'b1;
          if (pos == PW'(WINDOW_LENGTH - 1)) begin
            pos <= '0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_ROOT;
            cnt   <= CNTW'(SB - 1);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_ROOT: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          samp <= in_ext[SB-1:0];
        end
      end
      ST_LOAD: begin
        old   <= old_val;
        p_new <= {{SB{1'b0}}, samp};
        p_old <= {{SB{1'b0}}, old_val};
      end
      ST_SQR: begin
        p_new <= {sum_new, p_new[SB-1:1]};
        p_old <= {sum_old, p_old[SB-1:1]};
      end
      ST_SUM: begin
        dv      <= run_sum_next;
        div_rem <= '0;
      end
      ST_DIV: begin
        dv      <= {dv[SUM_W-2:0], div_q};
        div_rem <= div_rem_next;
        rm      <= '0;
        root    <= '0;
      end
      ST_ROOT: begin
        dv   <= {dv[SUM_W-3:0], 2'b00};
        rm   <= rm_next;
        root <= root_next;
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{(mwrt_pkg::OUT_W - mwrt_pkg::RMS_W - 1){1'b0}},
                      (root_ext < thr_ext), root_ext[mwrt_pkg::RMS_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // the running sum always contains the square that is about to leave
  `MWRT_ASSERT_SAME(a_sum_no_underflow, clk, rst, state == ST_SUM, run_sum >= SUM_W'(p_old))
  // divider remainder stays below the window length
  `MWRT_ASSERT_SAME(a_div_rem_bound, clk, rst, state == ST_DIV,
                    div_rem < RB'(WINDOW_LENGTH))
  // a new item is never taken while one is in flight
  `MWRT_ASSERT_NEXT(a_one_in_flight, clk, rst, s_accept, !s_tready)

endmodule

// ===== hw/rtl/mwrt_ram.sv =====
module mwrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
